>>> hw/rtl/mop_pkg.sv
// ----------------------------------------------------------------------------
// Median-of-three partition: shared definitions
// Widths of the payload fields and the default set capacity.
// ----------------------------------------------------------------------------
package mop_pkg;

    localparam int MAX_ELEMENTS_DEF = 32;
    localparam int VALUE_W          = 32;
    localparam int SPLIT_W          = 7;

endpackage

>>> hw/rtl/mop_if.sv
// ----------------------------------------------------------------------------
// Median-of-three partition: channel interfaces
// Valid/ready channels for loaded elements and for partitioned results.
// ----------------------------------------------------------------------------
interface mop_in_if;

    logic                        valid;
    logic                        ready;
    logic [mop_pkg::VALUE_W-1:0] value;
    logic                        last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);

endinterface

interface mop_out_if;

    logic                        valid;
    logic                        ready;
    logic [mop_pkg::VALUE_W-1:0] value_res;
    logic [mop_pkg::SPLIT_W-1:0] split_index;
    logic                        last_res;

    modport source (output valid, output value_res, output split_index, output last_res,
                    input ready);
    modport sink   (input valid, input value_res, input split_index, input last_res,
                    output ready);

endinterface

>>> hw/rtl/median_of_three_partition_unit.sv
// ----------------------------------------------------------------------------
// Median-of-three partition unit
// Collects a set of unsigned words, partitions it around a median-of-three
// pivot with a two-pointer scheme and streams the reordered set out.
// ----------------------------------------------------------------------------
// The load channel takes one element per transaction, one per cycle, until a
// transaction with last set; elements beyond MAX_ELEMENTS are dropped, but the
// last mark still closes the set. The block then stops taking transactions.
// Pivot selection takes three reads of the element memory. Each partition
// step reads and compares one entry at a time: the memory has one read and
// one write port and a single comparator serves every value comparison, so
// a swap costs two writes. The S_SPLIT state then fixes the split index.
// The result channel then carries one transaction per element; each is read
// from memory, loaded into the output register and held until its handshake
// before the next read, each with the split index and last_res set on the
// final element. A stalled receiver simply holds the block in its output
// wait; nothing is lost. After the final result the block returns to loading
// a new set. Reset clears the count, the pointers and the sequencer; memory
// contents are not cleared, and only entries of the current set are used.
// ----------------------------------------------------------------------------
module median_of_three_partition_unit #(
    parameter int MAX_ELEMENTS = mop_pkg::MAX_ELEMENTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    mop_in_if.sink          load,
    mop_out_if.source       result
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int PTR_W = CNT_W + 1;
    localparam int VW    = mop_pkg::VALUE_W;
    localparam int SW    = mop_pkg::SPLIT_W;

    localparam logic signed [PTR_W-1:0] PTR_ONE = PTR_W'(1);
    localparam logic signed [PTR_W-1:0] PTR_TWO = PTR_W'(2);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_PV0   = 4'd1;
    localparam logic [3:0] S_PV1   = 4'd2;
    localparam logic [3:0] S_PV2   = 4'd3;
    localparam logic [3:0] S_PV3   = 4'd4;
    localparam logic [3:0] S_PV4   = 4'd5;
    localparam logic [3:0] S_RDL   = 4'd6;
    localparam logic [3:0] S_CMPL  = 4'd7;
    localparam logic [3:0] S_RDR   = 4'd8;
    localparam logic [3:0] S_CMPR  = 4'd9;
    localparam logic [3:0] S_SWAP  = 4'd10;
    localparam logic [3:0] S_SPLIT = 4'd11;
    localparam logic [3:0] S_ERD   = 4'd12;
    localparam logic [3:0] S_EOUT  = 4'd13;
    localparam logic [3:0] S_EHOLD = 4'd14;

    logic [VW-1:0] mem [MAX_ELEMENTS];
    logic [VW-1:0] rdata_reg;

    logic [3:0]              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        k_reg, k_next;
    logic signed [PTR_W-1:0] lp_reg, lp_next;
    logic signed [PTR_W-1:0] rp_reg, rp_next;
    logic [VW-1:0]           pivot_reg, pivot_next;
    logic [VW-1:0]           a_reg, a_next;
    logic [VW-1:0]           b_reg, b_next;
    logic [VW-1:0]           c_reg, c_next;
    logic [VW-1:0]           lv_reg, lv_next;
    logic [SW-1:0]           split_reg, split_next;
    logic                    out_valid_reg, out_valid_next;
    logic [VW-1:0]           out_value_reg, out_value_next;
    logic                    out_last_reg, out_last_next;

    logic [IDX_W-1:0] raddr;
    logic [IDX_W-1:0] waddr;
    logic [VW-1:0]    wdata;
    logic             we;
    logic [VW-1:0]    cmp_a;
    logic [VW-1:0]    cmp_b;
    logic             lt;
    logic             emit_last;

    assign lt        = cmp_a < cmp_b;
    assign emit_last = (k_reg == (cnt_reg - CNT_W'(1)));

    assign load.ready         = (state_reg == S_LOAD);
    assign result.valid       = out_valid_reg;
    assign result.value_res   = out_value_reg;
    assign result.split_index = split_reg;
    assign result.last_res    = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        lp_next        = lp_reg;
        rp_next        = rp_reg;
        pivot_next     = pivot_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        lv_next        = lv_reg;
        split_next     = split_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        raddr          = '0;
        waddr          = IDX_W'(cnt_reg);
        wdata          = load.value;
        we             = 1'b0;
        cmp_a          = rdata_reg;
        cmp_b          = pivot_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (load.valid)
                begin
                    if (cnt_reg < CNT_W'(MAX_ELEMENTS))
                    begin
                        we       = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (load.last)
                    begin
                        state_next = S_PV0;
                    end
                end
            end
            S_PV0:
            begin
                raddr      = '0;
                state_next = S_PV1;
            end
            S_PV1:
            begin
                a_next     = rdata_reg;
                raddr      = IDX_W'(cnt_reg >> 1);
                state_next = S_PV2;
            end
            S_PV2:
            begin
                cmp_a = rdata_reg;
                cmp_b = a_reg;
                if (lt)
                begin
                    a_next = rdata_reg;
                    b_next = a_reg;
                end
                else
                begin
                    b_next = rdata_reg;
                end
                raddr      = IDX_W'(cnt_reg - CNT_W'(1));
                state_next = S_PV3;
            end
            S_PV3:
            begin
                cmp_a  = b_reg;
                cmp_b  = rdata_reg;
                c_next = rdata_reg;
                if (lt)
                begin
                    pivot_next = b_reg;
                    state_next = S_RDL;
                end
                else
                begin
                    state_next = S_PV4;
                end
            end
            S_PV4:
            begin
                cmp_a      = a_reg;
                cmp_b      = c_reg;
                pivot_next = lt ? c_reg : a_reg;
                state_next = S_RDL;
            end
            S_RDL:
            begin
                raddr = IDX_W'(lp_reg);
                if (lp_reg > rp_reg)
                begin
                    state_next = S_SPLIT;
                end
                else
                begin
                    state_next = S_CMPL;
                end
            end
            S_CMPL:
            begin
                cmp_a   = rdata_reg;
                cmp_b   = pivot_reg;
                lv_next = rdata_reg;
                raddr   = IDX_W'(rp_reg);
                if (lt)
                begin
                    lp_next    = lp_reg + PTR_ONE;
                    state_next = S_RDL;
                end
                else
                begin
                    state_next = S_CMPR;
                end
            end
            S_RDR:
            begin
                raddr = IDX_W'(rp_reg);
                if (lp_reg > rp_reg)
                begin
                    state_next = S_SPLIT;
                end
                else
                begin
                    state_next = S_CMPR;
                end
            end
            S_CMPR:
            begin
                cmp_a = pivot_reg;
                cmp_b = rdata_reg;
                if (lt)
                begin
                    rp_next    = rp_reg - PTR_ONE;
                    state_next = S_RDR;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = IDX_W'(lp_reg);
                    wdata      = rdata_reg;
                    state_next = S_SWAP;
                end
            end
            S_SWAP:
            begin
                we         = 1'b1;
                waddr      = IDX_W'(rp_reg);
                wdata      = lv_reg;
                lp_next    = lp_reg + PTR_ONE;
                rp_next    = rp_reg - PTR_ONE;
                state_next = S_RDL;
            end
            S_SPLIT:
            begin
                if ((lp_reg == rp_reg + PTR_TWO) && (lp_reg != PTR_ONE))
                begin
                    split_next = SW'(lp_reg - PTR_ONE);
                end
                else
                begin
                    split_next = SW'(lp_reg);
                end
                k_next     = '0;
                state_next = S_ERD;
            end
            S_ERD:
            begin
                raddr      = IDX_W'(k_reg);
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                out_valid_next = 1'b1;
                out_value_next = rdata_reg;
                out_last_next  = emit_last;
                state_next     = S_EHOLD;
            end
            S_EHOLD:
            begin
                if (result.ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        cnt_next   = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (state_reg == S_PV0)
        begin
            lp_next = '0;
            rp_next = $signed({1'b0, cnt_reg}) - PTR_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            k_reg         <= '0;
            lp_reg        <= '0;
            rp_reg        <= '0;
            pivot_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            lp_reg        <= lp_next;
            rp_reg        <= rp_next;
            pivot_reg     <= pivot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        c_reg         <= c_next;
        lv_reg        <= lv_next;
        split_reg     <= split_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

`ifndef NO_ASSERTIONS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(load.ready && result.valid))
        else $error("Load accepted while a result is pending.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("Element count exceeds capacity.");

    a_pointer_cross: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RDL || state_reg == S_RDR) |-> (lp_reg <= rp_reg + PTR_TWO))
        else $error("Partition pointers crossed by more than two.");

    a_split_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (split_reg <= SW'(cnt_reg)))
        else $error("Split index beyond the set size.");

    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.ready && result.last_res) |=> load.ready)
        else $error("Block did not return to loading after the final result.");
`endif

endmodule

>>> bench/median_of_three_partition_unit_test.sv
// ----------------------------------------------------------------------------
// Median-of-three partition unit: self-checking testbench
// Loads sets of unsigned words through the load channel and checks every
// partitioned result against an in-bench prediction of the pivot choice,
// the two-pointer partition and the split index. Both channels idle at
// random, and the receiver holds off for a long stretch once.
// ----------------------------------------------------------------------------
module median_of_three_partition_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_W      = mop_pkg::VALUE_W;
    localparam int SPLIT_W      = mop_pkg::SPLIT_W;
    localparam int SET_CAPACITY = mop_pkg::MAX_ELEMENTS_DEF;
    localparam int ITEM_TARGET  = 310;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 40;

    typedef logic [VALUE_W-1:0] word_t;
    typedef word_t word_q_t[$];

    typedef struct packed {
        logic [VALUE_W-1:0] value_res;
        logic [SPLIT_W-1:0] split_index;
        logic               last_res;
    } part_result_t;

    logic clk;
    logic rst_n;

    mop_in_if  load_ch ();
    mop_out_if result_ch ();

    median_of_three_partition_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load_ch),
        .result (result_ch)
    );

    word_q_t        loading_set;
    part_result_t   pending_results[$];
    int             failures;
    int             items_sent;
    bit             steady_flow;
    bit             hold_pending;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic word_t pick_value(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 7);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return {1'b1, {(VALUE_W-1){1'b0}}};
                    default: return {1'b0, {(VALUE_W-1){1'b1}}};
                endcase
            end
            default: return ~word_t'($urandom_range(0, 15));
        endcase
    endfunction

    // Pivot from the median of first, middle and final entries, then the
    // two-pointer partition; one expected result per stored element.
    function automatic void partition_set(word_q_t elems);
        word_t pivot;
        word_t tmp;
        int    n;
        int    lo;
        int    mid;
        int    lp;
        int    rp;
        int    split;
        part_result_t r;
        n   = elems.size();
        lo  = 0;
        mid = n / 2;
        if (elems[mid] < elems[lo])
        begin
            lo  = mid;
            mid = 0;
        end
        if (elems[mid] < elems[n-1])
            pivot = elems[mid];
        else if (elems[lo] < elems[n-1])
            pivot = elems[n-1];
        else
            pivot = elems[lo];
        lp = 0;
        rp = n - 1;
        while (lp <= rp)
        begin
            if (elems[lp] < pivot)
                lp++;
            else if (pivot < elems[rp])
                rp--;
            else
            begin
                tmp       = elems[lp];
                elems[lp] = elems[rp];
                elems[rp] = tmp;
                lp++;
                rp--;
            end
        end
        split = (lp == rp + 2 && lp - 1 != 0) ? lp - 1 : lp;
        for (int k = 0; k < n; k++)
        begin
            r.value_res   = elems[k];
            r.split_index = SPLIT_W'(split);
            r.last_res    = (k == n - 1);
            pending_results.push_back(r);
        end
    endfunction

    function automatic void absorb_element(word_t v, logic fin);
        if (loading_set.size() < SET_CAPACITY)
            loading_set.push_back(v);
        if (fin)
        begin
            partition_set(loading_set);
            loading_set.delete();
        end
    endfunction

    task automatic send_element(input word_t v, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            load_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        load_ch.valid <= 1'b1;
        load_ch.value <= v;
        load_ch.last  <= fin;
        @(posedge clk);
        while (!load_ch.ready)
            @(posedge clk);
        absorb_element(v, fin);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_set(input word_q_t vals);
        for (int i = 0; i < vals.size(); i++)
            send_element(vals[i], i == vals.size() - 1);
    endtask

    function automatic word_q_t random_set(int size, int mode);
        word_q_t vals;
        for (int i = 0; i < size; i++)
            vals.push_back(pick_value(mode));
        return vals;
    endfunction

    task automatic report_mismatch(input string field, input word_t want, input word_t got);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endtask

    task automatic test_directed_sets();
        send_set('{word_t'(5)});
        send_set('{'1, '0});
        send_set('{'0, '1});
        send_set('{word_t'(7), word_t'(7), word_t'(7)});
        send_set('{word_t'(9), word_t'(1), word_t'(5), word_t'(3)});
        send_set('{word_t'(1), word_t'(2), word_t'(3), word_t'(4), word_t'(5)});
        send_set('{'1, '1, '0, '0, word_t'(32'h8000_0000)});
    endtask

    task automatic test_store_full();
        send_set(random_set(SET_CAPACITY + 2, 1));
        send_set(random_set(SET_CAPACITY + 1, 0));
    endtask

    task automatic test_back_to_back();
        steady_flow = 1'b1;
        for (int s = 0; s < 4; s++)
            send_set(random_set($urandom_range(1, 10), $urandom_range(0, 3)));
        steady_flow = 1'b0;
    endtask

    task automatic test_result_backpressure();
        send_set(random_set(20, 0));
        hold_pending = 1'b1;
        send_set(random_set(12, 1));
    endtask

    task automatic test_random_sets();
        int r;
        int size;
        while (items_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                size = $urandom_range(1, 6);
            else if (r < 90)
                size = $urandom_range(7, 20);
            else if (r < 96)
                size = $urandom_range(21, SET_CAPACITY);
            else
                size = $urandom_range(SET_CAPACITY + 1, SET_CAPACITY + 4);
            send_set(random_set(size, $urandom_range(0, 3)));
        end
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        part_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: unexpected transaction, expected none, actual value_res %h",
                             $time, result_ch.value_res);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.value_res !== want.value_res)
                    report_mismatch("value_res", want.value_res, result_ch.value_res);
                if (result_ch.split_index !== want.split_index)
                    report_mismatch("split_index", want.split_index, result_ch.split_index);
                if (result_ch.last_res !== want.last_res)
                    report_mismatch("last_res", want.last_res, result_ch.last_res);
            end
        end
    end

    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        load_ch.valid = 1'b0;
        load_ch.value = '0;
        load_ch.last  = 1'b0;
        rst_n         = 1'b0;
        failures      = 0;
        items_sent    = 0;
        steady_flow   = 1'b0;
        hold_pending  = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_sets();
        test_store_full();
        test_back_to_back();
        test_result_backpressure();
        test_random_sets();
        load_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/mop_pkg.sv
hw/rtl/mop_if.sv
hw/rtl/median_of_three_partition_unit.sv
bench/median_of_three_partition_unit_test.sv
